@@ design/nsc_pkg.sv @@
// Shared types, constants and helpers for the nearest segment on contour block.
`timescale 1ns / 1ps
`default_nettype none
package nsc_pkg;

    localparam int MAX_VERTICES_DEF  = 64;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COUNT_W = 7;
    localparam int COORD_W = 16;
    localparam int DOT_W   = 22;
    localparam int THR_W   = 30;
    localparam int CFG_W   = 30;
    localparam int LEN_W   = 34;
    localparam int OPA_W   = 20;

    localparam logic [DOT_W-1:0] DOT_MAX       = 22'h3FFFFF;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 30'd3840;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_FIND  = 2'd1,
        MODE_COORD = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_COUNT     = 2'd0,
        CFG_ORIGIN_X  = 2'd1,
        CFG_ORIGIN_Y  = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_DIF,
        ST_MDX,
        ST_MDY,
        ST_MWX,
        ST_MWY,
        ST_CHK,
        ST_DIV,
        ST_MTX,
        ST_MTY,
        ST_EY,
        ST_MEX,
        ST_MEY,
        ST_CMP,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } t_div_req;

    function automatic logic signed [OPA_W-1:0] sat16(input logic signed [OPA_W-1:0] v);
        logic signed [OPA_W-1:0] r;
        if (v > OPA_W'(32767)) begin
            r = OPA_W'(32767);
        end else if (v < -OPA_W'(32768)) begin
            r = -OPA_W'(32768);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/nearest_segment_on_contour.sv @@
// Top level: vertex table, sequencer and shared datapath of the contour search.
`timescale 1ns / 1ps
`default_nettype none
// Holds a closed polygon in a single-port table and answers two queries on it. A find beat
// walks the segments in turn, up to a zero-length one that ends the walk, through one shared
// multiplier and a one-bit-per-cycle divider; a segment whose projection falls outside the
// segment skips the divide and distance steps. The input side is ready only while no query
// is in work; a finished result waits in the output register while loads are taken.
module nearest_segment_on_contour #(
    parameter int MAX_VERTICES  = nsc_pkg::MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = nsc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [nsc_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_mode,
    input  wire logic [5:0]                   i_vertex_index,
    input  wire logic signed [15:0]           i_point_x,
    input  wire logic signed [15:0]           i_point_y,
    input  wire logic [nsc_pkg::DOT_W-1:0]    i_dot_position,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [15:0]                o_out_x,
    output logic signed [15:0]                o_out_y,
    output logic [nsc_pkg::DOT_W-1:0]         o_out_dot_position,
    output logic                              o_near_found
);

    localparam int F   = FRACTION_BITS;
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int AW  = nsc_pkg::OPA_W;
    localparam int BW  = (F + 2 > AW) ? F + 2 : AW;
    localparam int PW  = AW + BW;
    localparam int TW  = F + 1;
    localparam int LW  = nsc_pkg::LEN_W;
    localparam int DW  = nsc_pkg::DOT_W;
    localparam int PSW = IW + F + 1;
    localparam logic [DW-1:0]       FMASK = DW'((64'd1 << F) - 64'd1);
    localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (F - 1));

    nsc_pkg::t_state r_state, n_state;
    nsc_pkg::t_mode  r_mode;

    logic [nsc_pkg::COUNT_W-1:0] r_vcount;
    logic signed [15:0]          r_ox, r_oy;
    logic [nsc_pkg::THR_W-1:0]   r_thr;

    logic [IW-1:0]           r_i;
    logic [31:0]             r_v1;
    logic signed [15:0]      r_qx, r_qy;
    logic signed [16:0]      r_dx, r_dy;
    logic signed [17:0]      r_p1x, r_p1y, r_wx, r_wy;
    logic [TW-1:0]           r_t;
    logic signed [PW-1:0]    r_acc;
    logic [LW-1:0]           r_len;
    logic signed [AW-1:0]    r_ex, r_ey;
    logic                    r_found;
    logic [nsc_pkg::THR_W-1:0] r_best_d;
    logic [DW-1:0]           r_best_pos;

    logic [CW-1:0]           w_n;
    logic [CW-1:0]           w_i1;
    logic [IW-1:0]           w_j;
    logic                    w_accept;
    logic                    w_we;
    logic [IW-1:0]           w_addr;
    logic [31:0]             w_rd;
    logic signed [AW-1:0]    w_ma;
    logic signed [BW-1:0]    w_mb;
    logic signed [PW-1:0]    w_p;
    logic signed [PW-1:0]    w_sum;
    logic signed [PW-1:0]    w_rnd;
    logic signed [AW-1:0]    w_proj;
    logic signed [15:0]      w_v1x, w_v1y, w_v2x, w_v2y;
    logic [DW-1:0]           w_seg;
    logic                    w_out_free;
    nsc_pkg::t_div_req       w_div_req;
    logic                    w_div_done;
    logic [TW-1:0]           w_quot;

    always_comb begin
        if (32'(r_vcount) > 32'(MAX_VERTICES)) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = CW'(r_vcount);
        end
    end

    assign w_i1     = CW'(r_i) + 1'b1;
    assign w_j      = (w_i1 == w_n) ? '0 : IW'(w_i1);
    assign w_accept = i_valid && o_ready;
    assign w_out_free = !o_valid || i_ready;
    assign w_seg    = DW'(i_dot_position >> F);

    assign w_v1x = r_v1[15:0];
    assign w_v1y = r_v1[31:16];
    assign w_v2x = w_rd[15:0];
    assign w_v2y = w_rd[31:16];

    assign w_sum = r_acc + w_p;
    assign w_rnd = (w_p + HALF) >>> F;

    nsc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata ({i_point_y, i_point_x}),
        .o_rdata (w_rd)
    );

    nsc_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    nsc_div #(
        .FRACTION_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        w_we      = 1'b0;
        w_addr    = r_i;
        w_ma      = '0;
        w_mb      = '0;
        w_proj    = AW'(w_rnd) + AW'(r_p1x);
        w_div_req = '{start: 1'b0, dividend: LW'(w_sum), divisor: r_len};
        unique case (r_state)
            nsc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                w_addr  = IW'(i_vertex_index);
                if (w_accept) begin
                    unique case (nsc_pkg::t_mode'(i_mode))
                        nsc_pkg::MODE_LOAD: begin
                            w_we = 32'(i_vertex_index) < 32'(MAX_VERTICES);
                        end
                        nsc_pkg::MODE_FIND: begin
                            n_state = (w_n == '0) ? nsc_pkg::ST_DONE : nsc_pkg::ST_RD1;
                        end
                        nsc_pkg::MODE_COORD: begin
                            n_state = (w_n == '0 || i_dot_position == '0) ?
                                      nsc_pkg::ST_DONE : nsc_pkg::ST_RD1;
                        end
                        nsc_pkg::MODE_RSVD: begin
                            n_state = nsc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            nsc_pkg::ST_RD1: n_state = nsc_pkg::ST_RD2;
            nsc_pkg::ST_RD2: begin
                w_addr  = w_j;
                n_state = nsc_pkg::ST_DIF;
            end
            nsc_pkg::ST_DIF: begin
                n_state = (r_mode == nsc_pkg::MODE_FIND) ? nsc_pkg::ST_MDX : nsc_pkg::ST_MTX;
            end
            nsc_pkg::ST_MDX: begin
                w_ma    = AW'(r_dx);
                w_mb    = BW'(r_dx);
                n_state = nsc_pkg::ST_MDY;
            end
            nsc_pkg::ST_MDY: begin
                w_ma    = AW'(r_dy);
                w_mb    = BW'(r_dy);
                n_state = nsc_pkg::ST_MWX;
            end
            nsc_pkg::ST_MWX: begin
                w_ma    = AW'(r_wx);
                w_mb    = BW'(r_dx);
                n_state = nsc_pkg::ST_MWY;
            end
            nsc_pkg::ST_MWY: begin
                w_ma    = AW'(r_wy);
                w_mb    = BW'(r_dy);
                n_state = nsc_pkg::ST_CHK;
            end
            nsc_pkg::ST_CHK: begin
                if (r_len == '0) begin
                    n_state = nsc_pkg::ST_DONE;
                end else if (w_sum[PW-1] || w_sum > $signed(PW'(r_len))) begin
                    n_state = nsc_pkg::ST_NEXT;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = nsc_pkg::ST_DIV;
                end
            end
            nsc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = nsc_pkg::ST_MTX;
                end
            end
            nsc_pkg::ST_MTX: begin
                w_ma    = AW'(r_dx);
                w_mb    = BW'({1'b0, r_t});
                n_state = nsc_pkg::ST_MTY;
            end
            nsc_pkg::ST_MTY: begin
                w_ma    = AW'(r_dy);
                w_mb    = BW'({1'b0, r_t});
                n_state = nsc_pkg::ST_EY;
            end
            nsc_pkg::ST_EY: begin
                w_proj  = AW'(w_rnd) + AW'(r_p1y);
                n_state = (r_mode == nsc_pkg::MODE_FIND) ? nsc_pkg::ST_MEX : nsc_pkg::ST_DONE;
            end
            nsc_pkg::ST_MEX: begin
                w_ma    = r_ex;
                w_mb    = BW'(r_ex);
                n_state = nsc_pkg::ST_MEY;
            end
            nsc_pkg::ST_MEY: begin
                w_ma    = r_ey;
                w_mb    = BW'(r_ey);
                n_state = nsc_pkg::ST_CMP;
            end
            nsc_pkg::ST_CMP: n_state = nsc_pkg::ST_NEXT;
            nsc_pkg::ST_NEXT: begin
                n_state = (w_i1 == w_n) ? nsc_pkg::ST_DONE : nsc_pkg::ST_RD1;
            end
            nsc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = nsc_pkg::ST_IDLE;
                end
            end
            default: n_state = nsc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_thr    <= nsc_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (nsc_pkg::t_cfg'(i_cfg_index))
                nsc_pkg::CFG_COUNT:     r_vcount <= i_cfg_data[nsc_pkg::COUNT_W-1:0];
                nsc_pkg::CFG_ORIGIN_X:  r_ox     <= i_cfg_data[15:0];
                nsc_pkg::CFG_ORIGIN_Y:  r_oy     <= i_cfg_data[15:0];
                nsc_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data[nsc_pkg::THR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (w_accept) begin
            r_found <= 1'b0;
        end else if (r_state == nsc_pkg::ST_CMP && w_sum < $signed(PW'(r_thr))
                     && (!r_found || w_sum < $signed(PW'(r_best_d)))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            nsc_pkg::ST_IDLE: begin
                r_mode     <= nsc_pkg::t_mode'(i_mode);
                r_qx       <= i_point_x;
                r_qy       <= i_point_y;
                r_best_pos <= '0;
                r_ex       <= '0;
                r_ey       <= '0;
                r_i        <= '0;
                r_t        <= TW'(i_dot_position & FMASK);
                if (i_mode == nsc_pkg::MODE_COORD && w_n != '0) begin
                    if (32'(w_seg) > 32'(w_n) - 32'd1) begin
                        r_i <= IW'(w_n - 1'b1);
                    end else begin
                        r_i <= IW'(w_seg);
                    end
                end
            end
            nsc_pkg::ST_RD2: r_v1 <= w_rd;
            nsc_pkg::ST_DIF: begin
                r_dx  <= 17'(w_v2x) - 17'(w_v1x);
                r_dy  <= 17'(w_v2y) - 17'(w_v1y);
                r_p1x <= 18'(w_v1x) + 18'(r_ox);
                r_p1y <= 18'(w_v1y) + 18'(r_oy);
                r_wx  <= 18'(r_qx) - (18'(w_v1x) + 18'(r_ox));
                r_wy  <= 18'(r_qy) - (18'(w_v1y) + 18'(r_oy));
            end
            nsc_pkg::ST_MDY: r_acc <= w_p;
            nsc_pkg::ST_MWX: r_len <= LW'(w_sum);
            nsc_pkg::ST_MWY: r_acc <= w_p;
            nsc_pkg::ST_DIV: r_t   <= w_quot;
            nsc_pkg::ST_EY,
            nsc_pkg::ST_MTY: begin
                if (r_mode == nsc_pkg::MODE_FIND) begin
                    if (r_state == nsc_pkg::ST_MTY) begin
                        r_ex <= AW'(r_qx) - w_proj;
                    end else begin
                        r_ey <= AW'(r_qy) - w_proj;
                    end
                end else begin
                    if (r_state == nsc_pkg::ST_MTY) begin
                        r_ex <= nsc_pkg::sat16(w_proj);
                    end else begin
                        r_ey <= nsc_pkg::sat16(w_proj);
                    end
                end
            end
            nsc_pkg::ST_MEY: r_acc <= w_p;
            nsc_pkg::ST_CMP: begin
                if (w_sum < $signed(PW'(r_thr)) && (!r_found || w_sum < $signed(PW'(r_best_d))))
                begin
                    r_best_d <= nsc_pkg::THR_W'(w_sum);
                    if (64'(PSW'(r_i) << F) + 64'(r_t) > 64'(nsc_pkg::DOT_MAX)) begin
                        r_best_pos <= nsc_pkg::DOT_MAX;
                    end else begin
                        r_best_pos <= DW'((PSW'(r_i) << F) + PSW'(r_t));
                    end
                end
            end
            nsc_pkg::ST_NEXT: r_i <= IW'(w_i1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == nsc_pkg::ST_DONE && w_out_free) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nsc_pkg::ST_DONE && w_out_free) begin
            if (r_mode == nsc_pkg::MODE_FIND) begin
                o_out_x            <= '0;
                o_out_y            <= '0;
                o_out_dot_position <= r_best_pos;
                o_near_found       <= r_found;
            end else begin
                o_out_x            <= r_ex[15:0];
                o_out_y            <= r_ey[15:0];
                o_out_dot_position <= '0;
                o_near_found       <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == nsc_pkg::MODE_FIND || i_mode == nsc_pkg::MODE_COORD))
        |=> !o_ready)
        else $error("input taken while a query is in work");
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == nsc_pkg::ST_DIV)
        else $error("divider finished outside the divide state");
    a_best_below_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsc_pkg::ST_CMP && r_found) |-> r_best_d < r_thr)
        else $error("kept distance not below threshold");
    a_found_no_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_near_found) |-> (o_out_x == '0 && o_out_y == '0))
        else $error("find result carries coordinates");
    a_done_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsc_pkg::ST_DONE && w_out_free) |=> o_valid)
        else $error("result not presented");
`endif

endmodule
`default_nettype wire

@@ design/nsc_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module nsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

@@ design/nsc_mul.sv @@
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module nsc_mul #(
    parameter int AW = 20,
    parameter int BW = 26
) (
    input  wire logic                    i_clk,
    input  wire logic signed [AW-1:0]    i_a,
    input  wire logic signed [BW-1:0]    i_b,
    output logic signed      [AW+BW-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= (AW+BW)'(i_a) * (AW+BW)'(i_b);
    end

endmodule
`default_nettype wire

@@ design/nsc_div.sv @@
// Restoring divider producing one quotient bit per cycle for the projection fraction.
`timescale 1ns / 1ps
`default_nettype none
module nsc_div #(
    parameter int FRACTION_BITS = nsc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire nsc_pkg::t_div_req       i_req,
    output logic                         o_done,
    output logic [FRACTION_BITS:0]       o_quot
);

    localparam int LW  = nsc_pkg::LEN_W;
    localparam int CNW = $clog2(FRACTION_BITS + 2);

    logic          r_busy;
    logic [CNW-1:0] r_cnt;
    logic [LW:0]   r_rem;
    logic [LW-1:0] r_den;
    logic [LW:0]   w_trial;
    logic          w_ge;

    assign w_trial = (r_cnt == '0) ? r_rem : {r_rem[LW-1:0], 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(FRACTION_BITS)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.dividend};
            r_den  <= i_req.divisor;
            o_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            o_quot <= {o_quot[FRACTION_BITS-1:0], w_ge};
        end
    end

endmodule
`default_nettype wire
